>>> rtl/rpfa_pkg.sv
// Package for the reference-counted page-frame allocator.
// Holds field widths, reset values, action and status codes, register indexes.
// No dependencies.
package rpfa_pkg;

    // field widths
    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // default number of managed frames
    localparam int PAGES_DEF = 4096;

    // register reset values
    localparam logic [FRAME_W-1:0] LOW_FRAME_RST  = FRAME_W'(256);
    localparam logic [FRAME_W-1:0] HIGH_FRAME_RST = FRAME_W'(4352);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_FRAME  = 1'b0,
        CFG_HIGH_FRAME = 1'b1
    } cfg_index_t;

    // request actions; the spare code changes no state but still gets an OK result
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_SHARE = 2'd2
    } action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_NO_FREE    = 2'd1,
        STS_OUT_RANGE  = 2'd2,
        STS_ALREADY_FREE = 2'd3
    } status_t;

endpackage

>>> rtl/rpfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the free-list link store and the reference-count store. No dependencies.
module rpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, data held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/refcounted_page_frame_allocator.sv
// Top level of the reference-counted page-frame allocator: control, free-list
// pointers, clearing pass and result register. Uses rpfa_pkg and rpfa_ram.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_action, s_frame
// m_        out        m_valid / m_ready   m_frame_out, m_status, m_ref_count
// cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// Each request is accepted in ST_IDLE, which reads the link and count
// memories; ST_READ then updates them and loads the result register.
// After reset a clearing pass initialises both memories; s_ready stays low
// during it, configuration writes are taken throughout.
// A new request is taken while a result waits in the output register; its
// update waits in ST_READ until that register is free.
module refcounted_page_frame_allocator
    import rpfa_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [FRAME_W-1:0]   s_frame,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAME_W-1:0]   m_frame_out,
    output logic [STATUS_W-1:0]  m_status,
    output logic [COUNT_W-1:0]   m_ref_count,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_wdata
);

    localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(PAGES - 1);
    localparam logic [FRAME_W:0]   PAGES_LIM = (FRAME_W + 1)'(PAGES);

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [FRAME_W-1:0] low_frame_reg, high_frame_reg;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;

    // latched request
    logic [ACTION_W-1:0] action_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                in_range_reg;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0]  m_frame_out_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_ref_count_reg;

    // memory ports
    logic               link_we, cnt_we;
    logic [IDX_W-1:0]   link_waddr, cnt_waddr;
    logic [IDX_W-1:0]   link_wdata, link_rdata;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

    logic               s_fire, out_free, done;
    logic [FRAME_W-1:0] s_diff;
    logic               s_in_range;

    logic [FRAME_W-1:0]  res_frame;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;
    logic [COUNT_W-1:0]  cnt_dec, cnt_inc;

    // handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign done     = (state_reg == ST_READ) && out_free;

    // frame range check and index at accept
    assign s_diff     = s_frame - low_frame_reg;
    assign s_in_range = (s_frame >= low_frame_reg) && (s_frame < high_frame_reg)
                        && ({1'b0, s_diff} < PAGES_LIM);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_frame_reg  <= LOW_FRAME_RST;
            high_frame_reg <= HIGH_FRAME_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LOW_FRAME:  low_frame_reg  <= cfg_wdata;
                CFG_HIGH_FRAME: high_frame_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg   <= s_action;
            frame_reg    <= s_frame;
            idx_reg      <= s_diff[IDX_W-1:0];
            in_range_reg <= s_in_range;
        end
    end

    assign cnt_dec = cnt_rdata - COUNT_W'(1);
    assign cnt_inc = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

    // update: clearing pass, or read-modify-write of one request
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        empty_next   = empty_reg;
        link_we      = 1'b0;
        link_waddr   = tail_reg;
        link_wdata   = idx_reg;
        cnt_we       = 1'b0;
        cnt_waddr    = idx_reg;
        cnt_wdata    = cnt_dec;
        res_frame    = frame_reg;
        res_status   = STS_OK;
        res_count    = '0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_INIT: begin
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = (clr_reg == LAST_IDX) ? '0 : clr_reg + IDX_W'(1);
                cnt_we     = 1'b1;
                cnt_waddr  = clr_reg;
                cnt_wdata  = '0;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    unique case (action_reg)
                        ACT_ALLOC: begin
                            if (empty_reg) begin
                                res_frame  = '0;
                                res_status = STS_NO_FREE;
                            end else begin
                                if (head_reg == tail_reg) begin
                                    empty_next = 1'b1;
                                end else begin
                                    head_next = link_rdata;
                                end
                                cnt_we    = 1'b1;
                                cnt_waddr = head_reg;
                                cnt_wdata = COUNT_W'(1);
                                res_frame = low_frame_reg + FRAME_W'(head_reg);
                                res_count = COUNT_W'(1);
                            end
                        end
                        ACT_FREE, ACT_SHARE: begin
                            if (!in_range_reg) begin
                                res_status = STS_OUT_RANGE;
                            end else if (cnt_rdata == '0) begin
                                res_status = STS_ALREADY_FREE;
                            end else if (action_reg == ACT_FREE) begin
                                cnt_we    = 1'b1;
                                res_count = cnt_dec;
                                // last reference gone: append at the tail
                                if (cnt_dec == '0) begin
                                    tail_next = idx_reg;
                                    if (empty_reg) begin
                                        head_next  = idx_reg;
                                        empty_next = 1'b0;
                                    end else begin
                                        link_we = 1'b1;
                                    end
                                end
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_inc;
                                res_count = cnt_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= LAST_IDX;
            empty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (done) begin
            m_frame_out_reg <= res_frame;
            m_status_reg    <= res_status;
            m_ref_count_reg <= res_count;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_frame_out = m_frame_out_reg;
    assign m_status    = m_status_reg;
    assign m_ref_count = m_ref_count_reg;

    // free-list link store, read at the head
    rpfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PAGES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (s_fire),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    // reference-count store, read at the requested frame
    rpfa_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (PAGES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (s_fire),
        .raddr (s_diff[IDX_W-1:0]),
        .rdata (cnt_rdata)
    );

    // checks
    a_done_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid)
        else $error("finished request did not present a result");

    a_no_free_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STS_NO_FREE) |-> (m_frame_out == '0 && m_ref_count == '0))
        else $error("empty allocate result carries a frame or count");

    a_reject_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STS_OUT_RANGE || m_status == STS_ALREADY_FREE))
        |-> (m_ref_count == '0))
        else $error("rejected request reports a count");

    a_writes_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_we || link_we) |-> (state_reg == ST_INIT || done))
        else $error("memory written outside clearing pass or update");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && !out_free) |=> (state_reg == ST_READ
            && $stable(head_reg) && $stable(tail_reg) && $stable(empty_reg)))
        else $error("free list changed while result was stalled");

endmodule
